[sv/cdl_pkg.sv]
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared codes and constants for the configuration directive lexer.
// ----------------------------------------------------------------------------
package cdl_pkg;

    localparam int LINE_BITS_DEFAULT = 20;
    localparam int TOKEN_BITS        = 13;
    localparam logic [TOKEN_BITS-1:0] MAX_TOKEN_RESET = 13'd4096;

    typedef enum logic [2:0] {
        KIND_CHAR  = 3'd0,
        KIND_WORD  = 3'd1,
        KIND_SEMI  = 3'd2,
        KIND_OPEN  = 3'd3,
        KIND_CLOSE = 3'd4,
        KIND_DONE  = 3'd5,
        KIND_ERROR = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_AFTER_QUOTE = 3'd0,
        ERR_EMPTY_STMT  = 3'd1,
        ERR_CLOSE_STMT  = 3'd2,
        ERR_UNEXP_END   = 3'd3,
        ERR_TOO_LONG    = 3'd4
    } err_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

endpackage

[sv/config_directive_lexer.sv]
// ----------------------------------------------------------------------------
// config_directive_lexer
// Byte-stream tokenizer for brace/semicolon configuration text: emits word
// characters, word ends, statement ends, block closes, end of input and errors.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tdata: byte_value; tuser: end_of_input
//  m_*      out  tdata: char_value, error_code, line_number; tuser: kind;
//                tlast: last_of_run
//  cfg_*    in   cfg_data: max_token_len
//
//  one input beat per cycle while s_tready is high; each beat makes
//  zero, one or two result beats; the lexer state updates in the accept
//  cycle; results land in a 4-entry queue read straight onto the m_* port
//  s_tready is high while the queue has room for two results, so a stalled
//  sink holds back input once three or more result beats are queued
//  reset puts the lexer at word start, line 1, limit 4096, queue empty
// ----------------------------------------------------------------------------
module config_directive_lexer #(
    parameter  int LINE_BITS = cdl_pkg::LINE_BITS_DEFAULT,
    localparam int TDATA_W   = ((11 + LINE_BITS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] byte_value
    input  logic                           s_tuser,   // [0] end_of_input
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [TDATA_W-1:0]             m_tdata,   // [7:0] char_value,
                                                      // [10:8] error_code,
                                                      // then line_number
    output logic [2:0]                     m_tuser,   // [2:0] kind
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdl_pkg::TOKEN_BITS-1:0] cfg_data
);
    import cdl_pkg::*;

    // lexer state
    logic                  ws_reg, ws_next;
    logic                  acq_reg, acq_next;
    logic                  cmt_reg, cmt_next;
    logic                  esc_reg, esc_next;
    logic                  dq_reg, dq_next;
    logic                  sq_reg, sq_next;
    logic                  dol_reg, dol_next;
    logic                  shw_reg, shw_next;
    logic [TOKEN_BITS-1:0] tok_reg, tok_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [TOKEN_BITS-1:0] max_len_reg;

    // results of the current beat
    logic [2:0] e_kind [2];
    logic [7:0] e_char [2];
    logic [2:0] e_err  [2];
    logic [1:0] e_n;

    logic [7:0] c;
    logic       eoi;
    logic       in_accept;
    logic       out_accept;
    logic       nl;
    logic       space;
    logic       too_long;
    logic       go_start;
    logic       proceed;
    logic       word_start;
    logic [7:0] quote_ch;

    assign c          = s_tdata;
    assign eoi        = s_tuser;
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;
    assign cfg_ready  = 1'b1;

    assign nl       = !eoi && (c == CH_LF);
    assign space    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    assign too_long = tok_reg >= max_len_reg;
    assign quote_ch = dq_reg ? CH_DQUOTE : CH_SQUOTE;

    always_comb
    begin
        ws_next   = ws_reg;
        acq_next  = acq_reg;
        cmt_next  = cmt_reg;
        esc_next  = esc_reg;
        dq_next   = dq_reg;
        sq_next   = sq_reg;
        dol_next  = dol_reg;
        shw_next  = shw_reg;
        tok_next  = tok_reg;
        line_next = line_reg;
        go_start  = 1'b0;
        proceed   = 1'b0;
        word_start = ws_reg;
        e_n       = 2'd0;
        for (int i = 0; i < 2; i++)
        begin
            e_kind[i] = KIND_CHAR;
            e_char[i] = 8'd0;
            e_err[i]  = ERR_AFTER_QUOTE;
        end

        if (eoi)
        begin
            go_start = 1'b1;
            if (!ws_reg || acq_reg || shw_reg)
            begin
                e_kind[0] = KIND_ERROR;
                e_err[0]  = ERR_UNEXP_END;
            end
            else
            begin
                e_kind[0] = KIND_DONE;
            end
            e_n = 2'd1;
        end
        else
        begin
            if (nl)
            begin
                cmt_next = 1'b0;
                if (line_reg != {LINE_BITS{1'b1}})
                    line_next = line_reg + 1'b1;
            end

            if (cmt_reg && !nl)
            begin
                // comment swallows the byte
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                if (too_long)
                begin
                    go_start  = 1'b1;
                    e_kind[0] = KIND_ERROR;
                    e_err[0]  = ERR_TOO_LONG;
                    e_n       = 2'd1;
                end
                else
                begin
                    tok_next = tok_reg + 1'b1;
                    e_n      = 2'd1;
                    case (c)
                        CH_LOW_T: e_char[0] = CH_TAB;
                        CH_LOW_R: e_char[0] = CH_CR;
                        CH_LOW_N: e_char[0] = CH_LF;
                        CH_DQUOTE, CH_SQUOTE, CH_BSLASH: e_char[0] = c;
                        default:
                        begin
                            // unknown escape keeps the backslash
                            e_char[0] = CH_BSLASH;
                            e_char[1] = c;
                            e_n       = 2'd2;
                        end
                    endcase
                end
            end
            else
            begin
                proceed = 1'b1;
                if (acq_reg)
                begin
                    proceed = 1'b0;
                    if (space)
                    begin
                        acq_next = 1'b0;
                        ws_next  = 1'b1;
                    end
                    else if (c == CH_SEMI || c == CH_LBRACE)
                    begin
                        go_start  = 1'b1;
                        e_kind[0] = (c == CH_SEMI) ? KIND_SEMI : KIND_OPEN;
                        e_n       = 2'd1;
                    end
                    else if (c != CH_RPAREN)
                    begin
                        go_start  = 1'b1;
                        e_kind[0] = KIND_ERROR;
                        e_err[0]  = ERR_AFTER_QUOTE;
                        e_n       = 2'd1;
                    end
                    else
                    begin
                        acq_next   = 1'b0;
                        proceed    = 1'b1;
                        word_start = 1'b1;
                    end
                end

                if (proceed && word_start)
                begin
                    if (space)
                    begin
                    end
                    else if (c == CH_SEMI || c == CH_LBRACE)
                    begin
                        go_start = 1'b1;
                        e_n      = 2'd1;
                        if (!shw_reg)
                        begin
                            e_kind[0] = KIND_ERROR;
                            e_err[0]  = ERR_EMPTY_STMT;
                        end
                        else
                        begin
                            e_kind[0] = (c == CH_SEMI) ? KIND_SEMI : KIND_OPEN;
                        end
                    end
                    else if (c == CH_RBRACE)
                    begin
                        go_start = 1'b1;
                        e_n      = 2'd1;
                        if (shw_reg)
                        begin
                            e_kind[0] = KIND_ERROR;
                            e_err[0]  = ERR_CLOSE_STMT;
                        end
                        else
                        begin
                            e_kind[0] = KIND_CLOSE;
                        end
                    end
                    else if (c == CH_HASH)
                    begin
                        cmt_next = 1'b1;
                    end
                    else if (max_len_reg == '0)
                    begin
                        // fresh word, count starts from zero
                        go_start  = 1'b1;
                        e_kind[0] = KIND_ERROR;
                        e_err[0]  = ERR_TOO_LONG;
                        e_n       = 2'd1;
                    end
                    else
                    begin
                        tok_next = {{(TOKEN_BITS-1){1'b0}}, 1'b1};
                        ws_next  = 1'b0;
                        if (c == CH_BSLASH)
                            esc_next = 1'b1;
                        else if (c == CH_DQUOTE)
                            dq_next = 1'b1;
                        else if (c == CH_SQUOTE)
                            sq_next = 1'b1;
                        else
                        begin
                            if (c == CH_DOLLAR)
                                dol_next = 1'b1;
                            e_char[0] = c;
                            e_n       = 2'd1;
                        end
                    end
                end
                else if (proceed)
                begin
                    // inside an open word
                    if (c == CH_LBRACE && dol_reg)
                    begin
                        if (too_long)
                        begin
                            go_start  = 1'b1;
                            e_kind[0] = KIND_ERROR;
                            e_err[0]  = ERR_TOO_LONG;
                        end
                        else
                        begin
                            tok_next  = tok_reg + 1'b1;
                            e_char[0] = c;
                        end
                        e_n = 2'd1;
                    end
                    else
                    begin
                        dol_next = 1'b0;
                        if ((dq_reg || sq_reg) && c == quote_ch)
                        begin
                            dq_next   = 1'b0;
                            sq_next   = 1'b0;
                            acq_next  = 1'b1;
                            shw_next  = 1'b1;
                            tok_next  = '0;
                            e_kind[0] = KIND_WORD;
                            e_n       = 2'd1;
                        end
                        else if (!dq_reg && !sq_reg && c != CH_BSLASH && c != CH_DOLLAR
                                 && (space || c == CH_SEMI || c == CH_LBRACE))
                        begin
                            shw_next  = 1'b1;
                            tok_next  = '0;
                            ws_next   = 1'b1;
                            e_kind[0] = KIND_WORD;
                            e_n       = 2'd1;
                            if (c == CH_SEMI || c == CH_LBRACE)
                            begin
                                go_start  = 1'b1;
                                e_kind[1] = (c == CH_SEMI) ? KIND_SEMI : KIND_OPEN;
                                e_n       = 2'd2;
                            end
                        end
                        else if (too_long)
                        begin
                            go_start  = 1'b1;
                            e_kind[0] = KIND_ERROR;
                            e_err[0]  = ERR_TOO_LONG;
                            e_n       = 2'd1;
                        end
                        else
                        begin
                            tok_next = tok_reg + 1'b1;
                            if (c == CH_BSLASH)
                                esc_next = 1'b1;
                            else
                            begin
                                if (c == CH_DOLLAR)
                                    dol_next = 1'b1;
                                e_char[0] = c;
                                e_n       = 2'd1;
                            end
                        end
                    end
                end
            end
        end

        if (go_start)
        begin
            ws_next  = 1'b1;
            acq_next = 1'b0;
            cmt_next = 1'b0;
            esc_next = 1'b0;
            dq_next  = 1'b0;
            sq_next  = 1'b0;
            dol_next = 1'b0;
            shw_next = 1'b0;
            tok_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= 1'b1;
            acq_reg     <= 1'b0;
            cmt_reg     <= 1'b0;
            esc_reg     <= 1'b0;
            dq_reg      <= 1'b0;
            sq_reg      <= 1'b0;
            dol_reg     <= 1'b0;
            shw_reg     <= 1'b0;
            tok_reg     <= '0;
            line_reg    <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            max_len_reg <= MAX_TOKEN_RESET;
        end
        else
        begin
            if (in_accept)
            begin
                ws_reg   <= ws_next;
                acq_reg  <= acq_next;
                cmt_reg  <= cmt_next;
                esc_reg  <= esc_next;
                dq_reg   <= dq_next;
                sq_reg   <= sq_next;
                dol_reg  <= dol_next;
                shw_reg  <= shw_next;
                tok_reg  <= tok_next;
                line_reg <= line_next;
            end
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
        end
    end

    // result queue
    logic [2:0]           q_kind [4];
    logic [7:0]           q_char [4];
    logic [2:0]           q_err  [4];
    logic [LINE_BITS-1:0] q_line [4];
    logic                 q_last [4];
    logic [1:0]           wr_ptr_reg, wr_ptr_next;
    logic [1:0]           rd_ptr_reg, rd_ptr_next;
    logic [2:0]           count_reg, count_next;
    logic [1:0]           push_n;
    logic [1:0]           wr_ptr_1;

    assign push_n   = in_accept ? e_n : 2'd0;
    assign wr_ptr_1 = wr_ptr_reg + 2'd1;
    assign s_tready = (count_reg <= 3'd2);
    assign m_tvalid = (count_reg != 3'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, out_accept};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, out_accept};
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_kind[wr_ptr_reg] <= e_kind[0];
            q_char[wr_ptr_reg] <= e_char[0];
            q_err[wr_ptr_reg]  <= e_err[0];
            q_line[wr_ptr_reg] <= line_next;
            q_last[wr_ptr_reg] <= (push_n == 2'd1);
        end
        if (push_n == 2'd2)
        begin
            q_kind[wr_ptr_1] <= e_kind[1];
            q_char[wr_ptr_1] <= e_char[1];
            q_err[wr_ptr_1]  <= e_err[1];
            q_line[wr_ptr_1] <= line_next;
            q_last[wr_ptr_1] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        m_tdata                  = '0;
        m_tdata[7:0]             = q_char[rd_ptr_reg];
        m_tdata[10:8]            = q_err[rd_ptr_reg];
        m_tdata[11 +: LINE_BITS] = q_line[rd_ptr_reg];
        m_tuser                  = q_kind[rd_ptr_reg];
        m_tlast                  = q_last[rd_ptr_reg];
    end

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_eoi_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && eoi) |=> (ws_reg && !shw_reg && !acq_reg && tok_reg == '0))
        else $error("end of input did not return to start");

    a_one_quote: assert property (@(posedge clk) disable iff (!rst_n)
        !(dq_reg && sq_reg))
        else $error("both quote modes open");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line count wrapped");

    a_escape_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> !ws_reg)
        else $error("escape pending outside a word");

endmodule
